@@ design/vad_pkg.sv @@
// Shared types, widths and constants for the vector angle core.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package vad_pkg;

    // Field widths
    localparam int COORD_W       = 32;
    localparam int DIFF_W        = COORD_W + 1;
    localparam int MR_W          = 16;
    localparam int SQ_W          = 2 * MR_W;
    localparam int ANGLE_W       = 25;

    // CORDIC setup
    localparam int CORDIC_STAGES = 24;
    localparam int FRACTION_BITS = 16;
    localparam int GUARD_SHIFT   = 24;
    localparam int STAGE_W       = $clog2(CORDIC_STAGES);

    // x/y carry the guard bits plus CORDIC gain headroom
    localparam int XY_W          = DIFF_W + GUARD_SHIFT + 2;
    // angle accumulator: degrees scaled by 2^32, range about -100 .. +280
    localparam int Z_W           = 43;
    localparam int SH            = 32 - FRACTION_BITS;
    localparam int R_W           = Z_W - SH;

    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [XY_W-1:0]    t_xy;
    typedef logic signed [Z_W-1:0]     t_z;
    typedef logic signed [R_W-1:0]     t_r;
    typedef logic [STAGE_W-1:0]        t_stage;
    typedef logic [MR_W-1:0]           t_mr;
    typedef logic [SQ_W-1:0]           t_sq;
    typedef logic [ANGLE_W-1:0]        t_angle;

    // Rotating vector and accumulated angle
    typedef struct packed {
        t_xy x;
        t_xy y;
        t_z  z;
    } t_vec;

    // Sideband that rides along the stage chain
    typedef struct packed {
        logic flag;   // radius below minimum
        logic zero;   // zero difference vector
    } t_side;

    typedef struct packed {
        t_angle angle_deg;
        logic   radius_too_small;
    } t_result;

    localparam t_z Z_HALF_TURN = t_z'(longint'(180) << 32);
    localparam t_z Z_ROUND     = t_z'(longint'(1) << (SH - 1));
    localparam t_r FULL_TURN   = t_r'(longint'(360) << FRACTION_BITS);

    // atan(2^-i) in degrees scaled by 2^32
    localparam int     TABLE_LEN       = 13;
    localparam longint DEG_PER_RAD_Q32 = 64'sd246083499208;
    localparam longint ATAN_TABLE [TABLE_LEN] = '{
        64'sd193273528320, 64'sd114096026022, 64'sd60285206653,
        64'sd30601712202,  64'sd15360239180,  64'sd7687607525,
        64'sd3844741810,   64'sd1922488225,   64'sd961258780,
        64'sd480631223,    64'sd240315841,    64'sd120157949,
        64'sd60078978
    };

    // Per-stage angle step; stages past the table use the small-angle form
    function automatic t_z atan_step(input t_stage i);
        longint v;
        if (i < TABLE_LEN) begin
            v = ATAN_TABLE[i[3:0]];
        end else begin
            v = (DEG_PER_RAD_Q32 + (longint'(1) << (i - 1))) >> i;
        end
        return t_z'(v);
    endfunction

endpackage

`default_nettype wire

@@ design/vad_if.sv @@
// Channel interfaces for the vector angle core: input, result and config.
// Depends on vad_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface vad_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [vad_pkg::COORD_W-1:0]  center_x;
    logic signed [vad_pkg::COORD_W-1:0]  center_y;
    logic signed [vad_pkg::COORD_W-1:0]  point_x;
    logic signed [vad_pkg::COORD_W-1:0]  point_y;
    modport source(output valid, center_x, center_y, point_x, point_y, input ready);
    modport sink(input valid, center_x, center_y, point_x, point_y, output ready);
endinterface

interface vad_out_if;
    logic                          valid;
    logic                          ready;
    logic [vad_pkg::ANGLE_W-1:0]   angle_deg;
    logic                          radius_too_small;
    modport source(output valid, angle_deg, radius_too_small, input ready);
    modport sink(input valid, angle_deg, radius_too_small, output ready);
endinterface

interface vad_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [vad_pkg::MR_W-1:0]      min_radius;
    modport source(output valid, min_radius, input ready);
    modport sink(input valid, min_radius, output ready);
endinterface

`default_nettype wire

@@ design/vad_front.sv @@
// Front end: difference vector, radius test and half-plane pre-rotation.
// Holds the min_radius register. Depends on vad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vad_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_cfg_we,
    input  logic [vad_pkg::MR_W-1:0]           i_cfg_min_radius,
    input  logic                               i_valid,
    input  logic signed [vad_pkg::COORD_W-1:0] i_center_x,
    input  logic signed [vad_pkg::COORD_W-1:0] i_center_y,
    input  logic signed [vad_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [vad_pkg::COORD_W-1:0] i_point_y,
    output logic                               o_valid,
    output vad_pkg::t_vec                      o_vec,
    output vad_pkg::t_side                     o_side
);

    vad_pkg::t_mr   r_min_radius;

    logic           r_a_v;
    vad_pkg::t_diff r_dx, r_dy;

    logic           r_b_v;
    logic           r_b_small, r_b_zero;
    vad_pkg::t_sq   r_sqx, r_sqy, r_mr2;
    vad_pkg::t_vec  r_b_vec;

    logic           r_c_v;
    vad_pkg::t_vec  r_c_vec;
    vad_pkg::t_side r_c_side;

    logic [vad_pkg::DIFF_W-1:0] w_adx, w_ady;
    vad_pkg::t_diff             w_rx, w_ry;
    vad_pkg::t_vec              n_b_vec;
    logic                       w_flag;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_radius <= vad_pkg::t_mr'(1);
        end else if (i_cfg_we) begin
            r_min_radius <= i_cfg_min_radius;
        end
    end

    // valid bits for the three front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    // stage A: difference vector at full width
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx <= {i_point_x[vad_pkg::COORD_W-1], i_point_x}
                  - {i_center_x[vad_pkg::COORD_W-1], i_center_x};
            r_dy <= {i_point_y[vad_pkg::COORD_W-1], i_point_y}
                  - {i_center_y[vad_pkg::COORD_W-1], i_center_y};
        end
    end

    // stage B: magnitudes, squares, and turn left-half vectors by 180 degrees
    always_comb begin
        w_adx = r_dx[vad_pkg::DIFF_W-1] ? -r_dx : r_dx;
        w_ady = r_dy[vad_pkg::DIFF_W-1] ? -r_dy : r_dy;
        w_rx  = r_dx[vad_pkg::DIFF_W-1] ? -r_dx : r_dx;
        w_ry  = r_dx[vad_pkg::DIFF_W-1] ? -r_dy : r_dy;
        n_b_vec.x = vad_pkg::t_xy'(w_rx) <<< vad_pkg::GUARD_SHIFT;
        n_b_vec.y = vad_pkg::t_xy'(w_ry) <<< vad_pkg::GUARD_SHIFT;
        n_b_vec.z = r_dx[vad_pkg::DIFF_W-1] ? vad_pkg::Z_HALF_TURN : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_small <= ~|w_adx[vad_pkg::DIFF_W-1:vad_pkg::MR_W]
                       & ~|w_ady[vad_pkg::DIFF_W-1:vad_pkg::MR_W];
            r_b_zero  <= (r_dx == '0) && (r_dy == '0);
            r_sqx     <= vad_pkg::t_sq'(w_adx[vad_pkg::MR_W-1:0])
                       * vad_pkg::t_sq'(w_adx[vad_pkg::MR_W-1:0]);
            r_sqy     <= vad_pkg::t_sq'(w_ady[vad_pkg::MR_W-1:0])
                       * vad_pkg::t_sq'(w_ady[vad_pkg::MR_W-1:0]);
            r_mr2     <= vad_pkg::t_sq'(r_min_radius) * vad_pkg::t_sq'(r_min_radius);
            r_b_vec   <= n_b_vec;
        end
    end

    // stage C: squared-length compare
    assign w_flag = r_b_small
                  && (({1'b0, r_sqx} + {1'b0, r_sqy}) < {1'b0, r_mr2});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_vec       <= r_b_vec;
            r_c_side.flag <= w_flag;
            r_c_side.zero <= r_b_zero;
        end
    end

    assign o_valid = r_c_v;
    assign o_vec   = r_c_vec;
    assign o_side  = r_c_side;

endmodule

`default_nettype wire

@@ design/vad_cell.sv @@
// One CORDIC vectoring stage: shift-add rotation toward the x axis.
// Depends on vad_pkg for the vector types and the angle step table.
`timescale 1ns / 1ps
`default_nettype none

module vad_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  vad_pkg::t_stage i_stage,
    input  logic            i_valid,
    input  vad_pkg::t_vec   i_vec,
    input  vad_pkg::t_side  i_side,
    output logic            o_valid,
    output vad_pkg::t_vec   o_vec,
    output vad_pkg::t_side  o_side
);

    logic           r_v;
    vad_pkg::t_vec  r_vec;
    vad_pkg::t_side r_side;

    vad_pkg::t_xy   w_x, w_y, w_xs, w_ys;
    vad_pkg::t_z    w_z, w_step;
    vad_pkg::t_vec  n_vec;

    // rotate by the stage angle in the direction that drives y to zero
    always_comb begin
        w_x    = i_vec.x;
        w_y    = i_vec.y;
        w_z    = i_vec.z;
        w_xs   = w_x >>> i_stage;
        w_ys   = w_y >>> i_stage;
        w_step = vad_pkg::atan_step(i_stage);
        if (w_y[vad_pkg::XY_W-1]) begin
            n_vec.x = w_x - w_ys;
            n_vec.y = w_y + w_xs;
            n_vec.z = w_z - w_step;
        end else begin
            n_vec.x = w_x + w_ys;
            n_vec.y = w_y - w_xs;
            n_vec.z = w_z + w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec  <= n_vec;
            r_side <= i_side;
        end
    end

    assign o_valid = r_v;
    assign o_vec   = r_vec;
    assign o_side  = r_side;

endmodule

`default_nettype wire

@@ design/vad_back.sv @@
// Back end: round the angle, wrap into [0, 360), output register and skid.
// Drives the chain enable. Depends on vad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vad_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  vad_pkg::t_vec              i_vec,
    input  vad_pkg::t_side             i_side,
    output logic                       o_en,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [vad_pkg::ANGLE_W-1:0] o_angle_deg,
    output logic                       o_radius_too_small
);

    logic              r_out_v, r_skid_v;
    vad_pkg::t_result  r_out, r_skid;

    vad_pkg::t_z       w_z, w_zr;
    vad_pkg::t_r       w_r, w_wrap;
    vad_pkg::t_result  w_res;
    logic              w_take;

    // round half up at the output precision, then wrap one turn
    always_comb begin
        w_z  = i_vec.z;
        w_zr = w_z + vad_pkg::Z_ROUND;
        w_r  = w_zr[vad_pkg::Z_W-1:vad_pkg::SH];
        if (w_r[vad_pkg::R_W-1]) begin
            w_wrap = w_r + vad_pkg::FULL_TURN;
        end else if (w_r >= vad_pkg::FULL_TURN) begin
            w_wrap = w_r - vad_pkg::FULL_TURN;
        end else begin
            w_wrap = w_r;
        end
        w_res.radius_too_small = i_side.flag;
        w_res.angle_deg = (i_side.flag || i_side.zero) ? '0
                        : vad_pkg::t_angle'(w_wrap);
    end

    assign w_take = r_out_v & i_ready;
    assign o_en   = ~r_skid_v;

    // output register with a one-entry skid; the chain stalls only when the skid is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_skid_v <= 1'b0;
            end
        end else if (i_valid) begin
            if (!r_out_v || w_take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (w_take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (i_valid) begin
            if (!r_out_v || w_take) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    assign o_valid            = r_out_v;
    assign o_angle_deg        = r_out.angle_deg;
    assign o_radius_too_small = r_out.radius_too_small;

endmodule

`default_nettype wire

@@ design/vector_angle_degrees_core.sv @@
// Top level of the vector angle core: front end, CORDIC cell chain, back end.
// Depends on vad_pkg, the channel interfaces, vad_front, vad_cell and vad_back.
//
// Takes a center and a point (signed Q16.16) and returns the angle of the point
// about the center in unsigned Q9.16 degrees, 0 up to below 360, with a flag when
// the distance is below min_radius (angle then 0). One item is accepted every
// clock while the chain is not stalled. Stages: three front stages (difference,
// squares and pre-rotation, radius compare), one register per CORDIC cell, and
// the rounding/output register. A one-entry skid behind it keeps input ready
// registered; the whole chain holds only when both output entries are full.
// min_radius resets to 1; config ready is always high. The user must write it on
// the config channel only while no item is in flight, not enforced by the core.
`timescale 1ns / 1ps
`default_nettype none

module vector_angle_degrees_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vad_cfg_if.sink    i_cfg,
    vad_in_if.sink     i_in,
    vad_out_if.source  o_out
);

    logic            w_en;
    logic            w_v    [vad_pkg::CORDIC_STAGES+1];
    vad_pkg::t_vec   w_vec  [vad_pkg::CORDIC_STAGES+1];
    vad_pkg::t_side  w_side [vad_pkg::CORDIC_STAGES+1];

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_en;

    vad_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (w_en),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_min_radius (i_cfg.min_radius),
        .i_valid          (i_in.valid),
        .i_center_x       (i_in.center_x),
        .i_center_y       (i_in.center_y),
        .i_point_x        (i_in.point_x),
        .i_point_y        (i_in.point_y),
        .o_valid          (w_v[0]),
        .o_vec            (w_vec[0]),
        .o_side           (w_side[0])
    );

    // CORDIC vectoring chain, one cell per stage
    for (genvar g = 0; g < vad_pkg::CORDIC_STAGES; g++) begin : g_cell
        vad_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (vad_pkg::t_stage'(g)),
            .i_valid (w_v[g]),
            .i_vec   (w_vec[g]),
            .i_side  (w_side[g]),
            .o_valid (w_v[g+1]),
            .o_vec   (w_vec[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    vad_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (w_v[vad_pkg::CORDIC_STAGES] & w_en),
        .i_vec              (w_vec[vad_pkg::CORDIC_STAGES]),
        .i_side             (w_side[vad_pkg::CORDIC_STAGES]),
        .o_en               (w_en),
        .o_valid            (o_out.valid),
        .i_ready            (o_out.ready),
        .o_angle_deg        (o_out.angle_deg),
        .o_radius_too_small (o_out.radius_too_small)
    );

endmodule

`default_nettype wire
